// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; pulled in with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ----- rtl/ps2mpd_pkg.sv -----
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; imported by every module of the block.
package ps2mpd_pkg;

	localparam int COORD_BITS = 10;
	localparam int SIZE_BITS  = 11;
	localparam int LIM_W = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
	localparam int SUM_W = ((COORD_BITS > 8) ? COORD_BITS : 8) + 2;
	localparam int CMP_W = ((LIM_W > SUM_W) ? LIM_W : SUM_W) + 1;

	localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(80);
	localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(25);
	localparam logic [COORD_BITS-1:0] CURSOR_X_RST = COORD_BITS'(RESET_WIDTH / 2);
	localparam logic [COORD_BITS-1:0] CURSOR_Y_RST = COORD_BITS'(RESET_HEIGHT / 2);

	// Bit positions inside packet bytes
	localparam int SYNC_BIT    = 3;
	localparam int BACK_BIT    = 4;
	localparam int FORWARD_BIT = 5;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_MODE   = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_STD      = 2'd0,
		MODE_WHEEL    = 2'd1,
		MODE_FIVE_BTN = 2'd2
	} mode_t;

	typedef struct packed {
		logic            done;
		mode_t           mode;
		logic [3:0][7:0] bytes;
	} pkt_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic signed [7:0]     delta_x;
		logic signed [7:0]     delta_y;
		logic signed [7:0]     delta_wheel;
		logic [4:0]            buttons;
		logic [4:0]            pressed;
		logic [4:0]            released;
		logic                  moved;
		logic [31:0]           count;
	} result_t;

endpackage

// ----- rtl/ps2mpd_assemble.sv -----
// Byte slot counter and held packet bytes; flags the byte that completes a packet.
// Depends on ps2mpd_pkg.
module ps2mpd_assemble (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_vld,
	input  logic [7:0]       rx,
	input  logic             advance,
	input  logic             enable,
	input  logic [1:0]       device_mode,
	output ps2mpd_pkg::pkt_t pkt
);
	import ps2mpd_pkg::*;

	logic [1:0] slot_q;
	logic [7:0] held_q [3];
	mode_t      mode;
	logic       take;

	always_comb begin
		unique case (device_mode)
			MODE_WHEEL:    mode = MODE_WHEEL;
			MODE_FIVE_BTN: mode = MODE_FIVE_BTN;
			default:       mode = MODE_STD;
		endcase
		// drop a would-be first byte without the sync bit
		take = byte_vld && enable && !(slot_q == 2'd0 && !rx[SYNC_BIT]);
		pkt.done = take && (slot_q == 2'd3 || (slot_q == 2'd2 && mode == MODE_STD));
		pkt.mode = mode;
		pkt.bytes[0] = held_q[0];
		pkt.bytes[1] = held_q[1];
		pkt.bytes[2] = (slot_q == 2'd2) ? rx : held_q[2];
		pkt.bytes[3] = (slot_q == 2'd3) ? rx : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 2'd0;
		end else if (advance && take) begin
			slot_q <= pkt.done ? 2'd0 : slot_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take && slot_q != 2'd3) begin
			held_q[slot_q] <= rx;
		end
	end

endmodule

// ----- rtl/ps2mpd_axis.sv -----
// Adds a signed delta to one cursor coordinate and clamps it to the screen size.
// Depends on ps2mpd_pkg.
module ps2mpd_axis (
	input  logic [ps2mpd_pkg::COORD_BITS-1:0] pos,
	input  logic signed [7:0]                 delta,
	input  logic [ps2mpd_pkg::SIZE_BITS-1:0]  size,
	output logic [ps2mpd_pkg::COORD_BITS-1:0] pos_next
);
	import ps2mpd_pkg::*;

	localparam logic [LIM_W-1:0] FULL = LIM_W'(1) << COORD_BITS;

	logic [LIM_W-1:0]        size_ext;
	logic [LIM_W-1:0]        lim;
	logic [LIM_W-1:0]        lim_m1;
	logic signed [SUM_W-1:0] pos_ext;
	logic signed [SUM_W-1:0] dlt_ext;
	logic signed [SUM_W-1:0] sum;

	always_comb begin
		size_ext = LIM_W'(size);
		// size zero acts as one, oversize stops at the coordinate range
		if (size_ext == '0) begin
			lim = LIM_W'(1);
		end else if (size_ext > FULL) begin
			lim = FULL;
		end else begin
			lim = size_ext;
		end
		lim_m1  = lim - LIM_W'(1);
		pos_ext = SUM_W'({1'b0, pos});
		dlt_ext = SUM_W'(delta);
		sum     = pos_ext + dlt_ext;
		if (sum[SUM_W-1]) begin
			pos_next = '0;
		end else if (CMP_W'($unsigned(sum)) >= CMP_W'(lim)) begin
			pos_next = lim_m1[COORD_BITS-1:0];
		end else begin
			pos_next = sum[COORD_BITS-1:0];
		end
	end

endmodule

// ----- rtl/ps2mpd_track.sv -----
// Cursor, button history and packet count; forms the result of a completed packet.
// Depends on ps2mpd_pkg and ps2mpd_axis.
module ps2mpd_track (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  ps2mpd_pkg::pkt_t                 pkt,
	input  logic [ps2mpd_pkg::SIZE_BITS-1:0] screen_width,
	input  logic [ps2mpd_pkg::SIZE_BITS-1:0] screen_height,
	output ps2mpd_pkg::result_t              res
);
	import ps2mpd_pkg::*;

	logic [COORD_BITS-1:0] cursor_x_q;
	logic [COORD_BITS-1:0] cursor_y_q;
	logic [4:0]            last_buttons_q;
	logic [31:0]           total_q;
	logic [COORD_BITS-1:0] next_x;
	logic [COORD_BITS-1:0] next_y;
	logic [4:0]            buttons;
	logic signed [7:0]     dz;
	logic signed [7:0]     dx;
	logic signed [7:0]     dy;

	assign dx = pkt.bytes[1];
	assign dy = pkt.bytes[2];

	ps2mpd_axis u_axis_x (
		.pos      (cursor_x_q),
		.delta    (dx),
		.size     (screen_width),
		.pos_next (next_x)
	);

	ps2mpd_axis u_axis_y (
		.pos      (cursor_y_q),
		.delta    (dy),
		.size     (screen_height),
		.pos_next (next_y)
	);

	always_comb begin
		buttons = {2'b00, pkt.bytes[0][2:0]};
		dz      = '0;
		unique case (pkt.mode)
			MODE_WHEEL: begin
				dz = pkt.bytes[3];
			end
			MODE_FIVE_BTN: begin
				// 4-bit wheel, upper nibble carries the extra buttons
				dz = 8'(signed'(pkt.bytes[3][3:0]));
				buttons[3] = pkt.bytes[3][BACK_BIT];
				buttons[4] = pkt.bytes[3][FORWARD_BIT];
			end
			default: begin
				dz = '0;
			end
		endcase

		res.pos_x       = next_x;
		res.pos_y       = next_y;
		res.delta_x     = dx;
		res.delta_y     = dy;
		res.delta_wheel = dz;
		res.buttons     = buttons;
		res.pressed     = buttons & ~last_buttons_q;
		res.released    = ~buttons & last_buttons_q;
		res.moved       = (next_x != cursor_x_q) || (next_y != cursor_y_q)
		                  || (dx != 8'sd0) || (dy != 8'sd0);
		res.count       = total_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= CURSOR_X_RST;
			cursor_y_q     <= CURSOR_Y_RST;
			last_buttons_q <= '0;
			total_q        <= '0;
		end else if (advance && pkt.done) begin
			cursor_x_q     <= next_x;
			cursor_y_q     <= next_y;
			last_buttons_q <= buttons;
			total_q        <= res.count;
		end
	end

endmodule

// ----- rtl/ps2_mouse_packet_decoder.sv -----
// PS/2 mouse packet decoder: one byte per cycle in, one result per completed packet out.
// A result is loaded into the result register once its completing byte leaves the input register.
// Throughput: one byte per cycle; a completing byte waits in the input register while a
// stalled result occupies the output. Reset clears slot, cursor (half screen), buttons,
// count and both handshake stages; registers return to enable 0, mode 0, 80 x 25.
// Depends on ps2mpd_pkg, ps2mpd_assemble, ps2mpd_track.
module ps2_mouse_packet_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [ps2mpd_pkg::SIZE_BITS-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ps2mpd_pkg::COORD_BITS-1:0] pos_x,
	output logic [ps2mpd_pkg::COORD_BITS-1:0] pos_y,
	output logic signed [7:0]                 delta_x,
	output logic signed [7:0]                 delta_y,
	output logic signed [7:0]                 delta_wheel,
	output logic [4:0]                        button_bits,
	output logic [4:0]                        pressed_edges,
	output logic [4:0]                        released_edges,
	output logic                              moved,
	output logic [31:0]                       packets_seen
);
	import ps2mpd_pkg::*;

	logic                 enable_q;
	logic [1:0]           mode_q;
	logic [SIZE_BITS-1:0] width_q;
	logic [SIZE_BITS-1:0] height_q;
	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 out_vld_q;
	result_t              res;
	result_t              res_q;
	pkt_t                 pkt;
	logic                 out_free;
	logic                 s1_go;
	logic                 in_acc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			mode_q   <= MODE_STD;
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    enable_q <= enable_q;
			endcase
		end
	end

	assign out_free = !out_vld_q || !out_stall;
	// a byte that completes a packet waits for room in the result register
	assign s1_go    = vld_s1 && (!pkt.done || out_free);
	assign in_stall = vld_s1 && !s1_go;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= rx_byte;
		end
	end

	ps2mpd_assemble u_assemble (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_vld    (vld_s1),
		.rx          (byte_s1),
		.advance     (s1_go),
		.enable      (enable_q),
		.device_mode (mode_q),
		.pkt         (pkt)
	);

	ps2mpd_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (s1_go),
		.pkt           (pkt),
		.screen_width  (width_q),
		.screen_height (height_q),
		.res           (res)
	);

	// result register: load a completed packet, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go && pkt.done) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && pkt.done) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_vld_q;
	assign pos_x          = res_q.pos_x;
	assign pos_y          = res_q.pos_y;
	assign delta_x        = res_q.delta_x;
	assign delta_y        = res_q.delta_y;
	assign delta_wheel    = res_q.delta_wheel;
	assign button_bits    = res_q.buttons;
	assign pressed_edges  = res_q.pressed;
	assign released_edges = res_q.released;
	assign moved          = res_q.moved;
	assign packets_seen   = res_q.count;

endmodule

// ----- rtl/ps2mpd_checker.sv -----
// Port-level checks for the PS/2 mouse packet decoder, bound to the top level.
// Depends on assert_macros.svh and ps2mpd_pkg.
`include "assert_macros.svh"

module ps2mpd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [ps2mpd_pkg::COORD_BITS-1:0] pos_x,
	input logic signed [7:0]                 delta_x,
	input logic signed [7:0]                 delta_y,
	input logic [4:0]                        button_bits,
	input logic [4:0]                        pressed_edges,
	input logic [4:0]                        released_edges,
	input logic                              moved,
	input logic [31:0]                       packets_seen
);

	logic [31:0] last_cnt_q;
	logic [31:0] cnt_next;
	logic        out_acc;
	logic        held;
	logic        edge_bad;
	logic        delta_nz;

	assign out_acc  = out_valid && !out_stall;
	assign held     = out_valid && out_stall;
	assign cnt_next = last_cnt_q + 32'd1;
	assign edge_bad = ((pressed_edges & ~button_bits) != 5'd0)
	                  || ((released_edges & button_bits) != 5'd0);
	assign delta_nz = (delta_x != 8'sd0) || (delta_y != 8'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q <= '0;
		end else if (out_acc) begin
			last_cnt_q <= packets_seen;
		end
	end

	`ASSERT_CLK(a_stall_hold, clk, arst_n, held |=> out_valid && $stable(pos_x), "stall hold")
	`ASSERT_CLK(a_count_step, clk, arst_n, out_acc |-> packets_seen == cnt_next, "count skipped")
	`ASSERT_NEVER(a_edge_mismatch, clk, arst_n, out_valid && edge_bad, "edge flags disagree")
	`ASSERT_NEVER(a_moved_flag, clk, arst_n, out_valid && !moved && delta_nz, "delta not moved")

endmodule

bind ps2_mouse_packet_decoder ps2mpd_checker u_ps2mpd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.pos_x          (pos_x),
	.delta_x        (delta_x),
	.delta_y        (delta_y),
	.button_bits    (button_bits),
	.pressed_edges  (pressed_edges),
	.released_edges (released_edges),
	.moved          (moved),
	.packets_seen   (packets_seen)
);

// ----- verif/ps2_mouse_packet_decoder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ps2_mouse_packet_decoder: byte stream in, decoded packets out.
// Depends on ps2mpd_pkg and the decoder RTL; needs no files or arguments at run time.
module ps2_mouse_packet_decoder_tb;
	import ps2mpd_pkg::*;

	localparam logic [1:0] MODE_UNDEFINED = 2'd3;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_EVERY_THIRD
	} stall_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_index = REG_ENABLE;
	logic [SIZE_BITS-1:0]  cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            rx_byte = 8'h00;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic signed [7:0]     delta_x;
	logic signed [7:0]     delta_y;
	logic signed [7:0]     delta_wheel;
	logic [4:0]            button_bits;
	logic [4:0]            pressed_edges;
	logic [4:0]            released_edges;
	logic                  moved;
	logic [31:0]           packets_seen;

	ps2_mouse_packet_decoder DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.delta_x        (delta_x),
		.delta_y        (delta_y),
		.delta_wheel    (delta_wheel),
		.button_bits    (button_bits),
		.pressed_edges  (pressed_edges),
		.released_edges (released_edges),
		.moved          (moved),
		.packets_seen   (packets_seen)
	);

	always #10 clk = ~clk;

	// Register shadow of the decoder
	logic                 cur_enable = 1'b0;
	logic [1:0]           cur_mode = MODE_STD;
	logic [SIZE_BITS-1:0] cur_width = RESET_WIDTH;
	logic [SIZE_BITS-1:0] cur_height = RESET_HEIGHT;

	// Tracking state of the decoder
	int unsigned           slot_count = 0;
	logic [7:0]            stash [3] = '{8'h00, 8'h00, 8'h00};
	logic [COORD_BITS-1:0] track_x = CURSOR_X_RST;
	logic [COORD_BITS-1:0] track_y = CURSOR_Y_RST;
	logic [4:0]            prev_buttons = '0;
	logic [31:0]           seen_total = '0;

	logic [7:0] byte_feed [$];
	result_t    predicted_packets [$];

	logic        in_taken = 1'b0;
	int          burst_left = 8;
	int          gap_left = 0;
	logic [15:0] stall_tick = '0;
	int          error_count = 0;

	function automatic logic [COORD_BITS-1:0] clamp_axis(input logic [COORD_BITS-1:0] pos,
			input int delta, input logic [SIZE_BITS-1:0] size);
		int lim;
		int v;
		lim = int'(size);
		if (lim < 1) lim = 1;
		if (lim > (1 << COORD_BITS)) lim = 1 << COORD_BITS;
		v = int'(pos) + delta;
		if (v < 0) v = 0;
		if (v >= lim) v = lim - 1;
		return COORD_BITS'(v);
	endfunction

	function automatic void decode_mouse_byte(input logic [7:0] b);
		mode_t                 pkt_mode;
		int                    pkt_len;
		int unsigned           slot;
		logic [7:0]            pk [4];
		int                    dx;
		int                    dy;
		int                    dz;
		logic [4:0]            btn;
		logic [3:0]            nib;
		logic [COORD_BITS-1:0] old_x;
		logic [COORD_BITS-1:0] old_y;
		result_t               r;
		if (!cur_enable) return;
		slot = slot_count;
		// drop bytes that cannot start a packet
		if (slot == 0 && !b[SYNC_BIT]) return;
		pkt_mode = (cur_mode == MODE_WHEEL || cur_mode == MODE_FIVE_BTN) ?
			mode_t'(cur_mode) : MODE_STD;
		pkt_len = (pkt_mode == MODE_STD) ? 3 : 4;
		pk[0] = stash[0];
		pk[1] = stash[1];
		pk[2] = stash[2];
		pk[3] = 8'h00;
		pk[slot] = b;
		if (slot < 3) stash[slot] = b;
		if (int'(slot) + 1 < pkt_len) begin
			slot_count = slot + 1;
			return;
		end
		slot_count = 0;

		dx = int'($signed(pk[1]));
		dy = int'($signed(pk[2]));
		btn = {2'b00, pk[0][2:0]};
		dz = 0;
		if (pkt_mode == MODE_WHEEL) begin
			dz = int'($signed(pk[3]));
		end else if (pkt_mode == MODE_FIVE_BTN) begin
			nib = pk[3][3:0];
			dz = int'($signed(nib));
			btn[3] = pk[3][BACK_BIT];
			btn[4] = pk[3][FORWARD_BIT];
		end

		old_x = track_x;
		old_y = track_y;
		track_x = clamp_axis(track_x, dx, cur_width);
		track_y = clamp_axis(track_y, dy, cur_height);
		seen_total = seen_total + 32'd1;

		r.pos_x = track_x;
		r.pos_y = track_y;
		r.delta_x = 8'(dx);
		r.delta_y = 8'(dy);
		r.delta_wheel = 8'(dz);
		r.buttons = btn;
		r.pressed = btn & ~prev_buttons;
		r.released = ~btn & prev_buttons;
		r.moved = (track_x != old_x || track_y != old_y || dx != 0 || dy != 0);
		r.count = seen_total;
		prev_buttons = btn;
		predicted_packets.push_back(r);
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// Compare outgoing transactions, then predict from the incoming one
	always @(posedge clk) begin : result_check
		result_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_packets.size() == 0) begin
					$error("unexpected result transaction: pos_x %0d pos_y %0d count %0d",
						pos_x, pos_y, packets_seen);
					error_count++;
				end else begin
					want = predicted_packets.pop_front();
					check_field("pos_x", want.pos_x, pos_x);
					check_field("pos_y", want.pos_y, pos_y);
					check_field("delta_x", $signed(want.delta_x), delta_x);
					check_field("delta_y", $signed(want.delta_y), delta_y);
					check_field("delta_wheel", $signed(want.delta_wheel), delta_wheel);
					check_field("button_bits", want.buttons, button_bits);
					check_field("pressed_edges", want.pressed, pressed_edges);
					check_field("released_edges", want.released, released_edges);
					check_field("moved", want.moved, moved);
					check_field("packets_seen", want.count, packets_seen);
				end
			end
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) decode_mouse_byte(rx_byte);
		end
	end

	// Sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (byte_feed.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= byte_feed.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: rotate through stall styles on a free-running tick counter
	always @(negedge clk) begin
		stall_tick <= stall_tick + 16'd1;
		case (stall_style_t'(stall_tick[8:7]))
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
			default:     out_stall <= (stall_tick % 3 == 0);
		endcase
	end

	task automatic write_reg(input reg_index_t idx, input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= SIZE_BITS'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE: cur_enable = value[0];
			REG_MODE:   cur_mode = value[1:0];
			REG_WIDTH:  cur_width = value[SIZE_BITS-1:0];
			default:    cur_height = value[SIZE_BITS-1:0];
		endcase
	endtask

	// Hold until every byte is taken, every result has arrived and the pipe is empty
	task automatic wait_idle();
		while (byte_feed.size() != 0 || in_valid) @(posedge clk);
		while (predicted_packets.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] movement_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h7F;
			1:       return 8'h80;
			2:       return 8'h00;
			3:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_packet(input int k, input bit push_hard);
		byte_feed.push_back(8'($urandom) | 8'h08);
		for (int i = 1; i < k; i++)
			byte_feed.push_back(push_hard ? 8'h7F : movement_byte());
	endtask

	function automatic int packet_len();
		return (cur_mode == MODE_WHEEL || cur_mode == MODE_FIVE_BTN) ? 4 : 3;
	endfunction

	// Mostly whole packets, some truncated or wrong-length ones, some stray bytes
	task automatic queue_traffic(input int count);
		int len;
		int n;
		int pick;
		int k;
		len = packet_len();
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) k = len;
			else if (pick < 88) k = $urandom_range(1, len - 1);
			else if (pick < 94) k = 7 - len;
			else k = 0;
			if (k == 0) begin
				byte_feed.push_back(8'($urandom));
				n++;
			end else begin
				queue_packet(k, 1'b0);
				n += k;
			end
		end
	endtask

	task automatic run_phase(input bit en, input int unsigned md, input int unsigned w,
			input int unsigned h);
		write_reg(REG_ENABLE, en);
		write_reg(REG_MODE, md);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		@(posedge clk);
		if (en) begin
			// drive the cursor into the far corner on wide screens
			if (w > 1023 || h > 1023)
				repeat (9) queue_packet(packet_len(), 1'b1);
			queue_traffic(75);
		end else begin
			repeat (40) byte_feed.push_back(8'($urandom));
		end
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Standard mode at reset size: dropped stray byte, full-scale deltas, button edges
		write_reg(REG_ENABLE, 1);
		@(posedge clk);
		byte_feed = {8'h00, 8'h0F, 8'h7F, 8'h80, 8'h08, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F};
		wait_idle();

		write_reg(REG_MODE, MODE_WHEEL);
		@(posedge clk);
		byte_feed = {8'h09, 8'h01, 8'hFF, 8'h80};
		wait_idle();

		// Negative wheel nibble with back and forward, then leave three bytes held
		write_reg(REG_MODE, MODE_FIVE_BTN);
		@(posedge clk);
		byte_feed = {8'h0C, 8'h10, 8'h10, 8'h38, 8'h08, 8'h05, 8'h05};
		wait_idle();

		// Switch to three-byte packets: next byte completes from the held bytes
		write_reg(REG_MODE, MODE_STD);
		@(posedge clk);
		byte_feed = {8'h00};
		wait_idle();

		run_phase(1, MODE_STD, 80, 25);
		run_phase(1, MODE_WHEEL, 1024, 1024);
		run_phase(1, MODE_FIVE_BTN, 1, 1);
		// leave a packet half built across the disabled phase
		@(posedge clk);
		byte_feed = {8'h0B, 8'h11};
		wait_idle();
		run_phase(0, MODE_FIVE_BTN, 640, 480);
		run_phase(1, MODE_FIVE_BTN, 640, 480);
		run_phase(1, MODE_UNDEFINED, 0, 2047);
		run_phase(1, MODE_WHEEL, 17, 1000);
		run_phase(1, MODE_FIVE_BTN, 1024, 3);
		run_phase(1, MODE_STD, 2047, 0);
		repeat (2)
			run_phase(1, $urandom_range(0, 3), $urandom_range(0, 2047), $urandom_range(0, 2047));

		repeat (6) @(posedge clk);
		if (error_count == 0) begin
			$display("ps2_mouse_packet_decoder regression: pass");
		end else begin
			$display("ps2_mouse_packet_decoder regression: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("ps2_mouse_packet_decoder regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ps2mpd_pkg.sv
rtl/ps2mpd_assemble.sv
rtl/ps2mpd_axis.sv
rtl/ps2mpd_track.sv
rtl/ps2_mouse_packet_decoder.sv
rtl/ps2mpd_checker.sv
verif/ps2_mouse_packet_decoder_tb.sv
